FILE: sv/hrhp_pkg.sv
// ----------------------------------------------------------------------------
// hrhp_pkg
// Types, codes and reset values shared by the HTTP request header parser.
// ----------------------------------------------------------------------------
package hrhp_pkg;

  // Parser phase
  typedef enum logic [1:0] {
    PH_LINE = 2'd0,
    PH_HDR  = 2'd1,
    PH_DONE = 2'd2,
    PH_ERR  = 2'd3
  } phase_e;

  // Request line substates
  typedef enum logic [2:0] {
    LN_METHOD_START = 3'd0,
    LN_METHOD       = 3'd1,
    LN_AFTER_METHOD = 3'd2,
    LN_PATH         = 3'd3,
    LN_AFTER_PATH   = 3'd4,
    LN_VERSION      = 3'd5,
    LN_CR           = 3'd6
  } line_e;

  // Header line substates
  typedef enum logic [2:0] {
    HD_KEY_START   = 3'd0,
    HD_KEY         = 3'd1,
    HD_COLON       = 3'd2,
    HD_AFTER_COLON = 3'd3,
    HD_VALUE       = 3'd4,
    HD_VALUE_CR    = 3'd5,
    HD_BLANK_CR    = 3'd6
  } hdr_e;

  // Field tags on the result
  typedef enum logic [2:0] {
    TAG_NONE    = 3'd0,
    TAG_METHOD  = 3'd1,
    TAG_PATH    = 3'd2,
    TAG_VERSION = 3'd3,
    TAG_KEY     = 3'd4,
    TAG_VALUE   = 3'd5
  } tag_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_MORE = 3'd0,
    ST_LINE = 3'd1,
    ST_HDRS = 3'd2,
    ST_ERR  = 3'd3,
    ST_SKIP = 3'd4
  } status_e;

  // Minimum method length; the counter saturates here
  localparam logic [1:0] MIN_METHOD = 2'd2;

  // Parser state
  typedef struct packed {
    phase_e     phase;
    line_e      line_sub;
    hdr_e       hdr_sub;
    logic [1:0] method_cnt;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:      PH_LINE,
    line_sub:   LN_METHOD_START,
    hdr_sub:    HD_KEY_START,
    method_cnt: 2'd0
  };

  // Input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [2:0] field_tag;
    logic [7:0] field_byte;
    logic       pair_done;
    logic [2:0] status;
  } out_item_t;

endpackage

FILE: sv/hrhp_stream_if.sv
// ----------------------------------------------------------------------------
// hrhp_stream_if
// Valid/ready channel carrying one item per handshake.
// ----------------------------------------------------------------------------
interface hrhp_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

FILE: sv/hrhp_step.sv
// ----------------------------------------------------------------------------
// hrhp_step
// One byte through the request line and header state machines.
// ----------------------------------------------------------------------------
module hrhp_step (
  input  hrhp_pkg::state_t    state_i,
  input  hrhp_pkg::in_item_t  item_i,
  output hrhp_pkg::state_t    state_o,
  output hrhp_pkg::out_item_t result_o
);
  import hrhp_pkg::*;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09;
  endfunction

  function automatic logic is_key_char(input logic [7:0] c);
    return is_alpha(c) || c == 8'h2D || c == 8'h5F || c == 8'h7E || c == 8'h2E;
  endfunction

  function automatic logic is_path_char(input logic [7:0] c);
    return c == 8'h2F || c == 8'h2E || c == 8'h5F || c == 8'h2D ||
           is_alpha(c) || is_digit(c);
  endfunction

  state_t     cur;
  state_t     nxt;
  tag_e       tag;
  logic       pair;
  status_e    status;
  logic [7:0] c;

  assign c = item_i.data_byte;

  // Restart drops back to the reset state before this byte is handled
  assign cur = item_i.restart ? STATE_RESET : state_i;

  always_comb begin
    nxt    = cur;
    tag    = TAG_NONE;
    pair   = 1'b0;
    status = ST_MORE;

    unique case (cur.phase)
      PH_DONE: status = ST_HDRS;
      PH_ERR:  status = ST_ERR;

      // Request line: method, blanks, path, blanks, version, CR LF
      PH_LINE: begin
        unique case (cur.line_sub)
          LN_METHOD_START: begin
            if (!is_alpha(c)) begin
              status = ST_ERR;
            end else begin
              nxt.line_sub   = LN_METHOD;
              nxt.method_cnt = 2'd1;
              tag            = TAG_METHOD;
            end
          end
          LN_METHOD: begin
            if (is_blank(c)) begin
              if (cur.method_cnt < MIN_METHOD) status = ST_ERR;
              else nxt.line_sub = LN_AFTER_METHOD;
            end else if (!is_alpha(c)) begin
              status = ST_ERR;
            end else begin
              if (cur.method_cnt < MIN_METHOD) nxt.method_cnt = cur.method_cnt + 2'd1;
              tag = TAG_METHOD;
            end
          end
          LN_AFTER_METHOD: begin
            if (is_blank(c)) begin
              status = ST_SKIP;
            end else if (c != 8'h2F) begin
              status = ST_ERR;
            end else begin
              nxt.line_sub = LN_PATH;
              tag          = TAG_PATH;
            end
          end
          LN_PATH: begin
            if (is_path_char(c)) tag = TAG_PATH;
            else if (is_blank(c)) nxt.line_sub = LN_AFTER_PATH;
            else status = ST_ERR;
          end
          LN_AFTER_PATH: begin
            if (is_blank(c)) begin
              status = ST_SKIP;
            end else if (!is_alpha(c)) begin
              status = ST_ERR;
            end else begin
              nxt.line_sub = LN_VERSION;
              tag          = TAG_VERSION;
            end
          end
          LN_VERSION: begin
            if (c == 8'h2E || c == 8'h2F || is_alpha(c) || is_digit(c)) tag = TAG_VERSION;
            else if (c == CH_CR) nxt.line_sub = LN_CR;
            else status = ST_ERR;
          end
          LN_CR: begin
            if (c != CH_LF) begin
              status = ST_ERR;
            end else begin
              nxt.phase   = PH_HDR;
              nxt.hdr_sub = HD_KEY_START;
              status      = ST_LINE;
            end
          end
          default: status = ST_ERR;
        endcase
      end

      // Header lines: key ':' ' ' value CR LF, blank CR LF ends them
      PH_HDR: begin
        unique case (cur.hdr_sub)
          HD_KEY_START: begin
            if (c == CH_CR) begin
              nxt.hdr_sub = HD_BLANK_CR;
            end else if (!is_key_char(c)) begin
              status = ST_ERR;
            end else begin
              nxt.hdr_sub = HD_KEY;
              tag         = TAG_KEY;
            end
          end
          HD_KEY: begin
            if (is_key_char(c)) tag = TAG_KEY;
            else if (c == 8'h3A) nxt.hdr_sub = HD_COLON;
            else status = ST_ERR;
          end
          HD_COLON: begin
            if (c != 8'h20) status = ST_ERR;
            else nxt.hdr_sub = HD_AFTER_COLON;
          end
          HD_AFTER_COLON: begin
            if (is_blank(c)) begin
              status = ST_SKIP;
            end else if (c == CH_CR || c == CH_LF) begin
              status = ST_ERR;
            end else begin
              nxt.hdr_sub = HD_VALUE;
              tag         = TAG_VALUE;
            end
          end
          HD_VALUE: begin
            if (c == CH_CR) nxt.hdr_sub = HD_VALUE_CR;
            else if (c == CH_LF) status = ST_ERR;
            else tag = TAG_VALUE;
          end
          HD_VALUE_CR: begin
            if (c != CH_LF) begin
              status = ST_ERR;
            end else begin
              nxt.hdr_sub = HD_KEY_START;
              pair        = 1'b1;
            end
          end
          HD_BLANK_CR: begin
            if (c != CH_LF) begin
              status = ST_ERR;
            end else begin
              nxt.phase = PH_DONE;
              status    = ST_HDRS;
            end
          end
          default: status = ST_ERR;
        endcase
      end

      default: status = ST_ERR;
    endcase

    // Any error is sticky and drops the tag and pair mark
    if (status == ST_ERR) begin
      nxt.phase = PH_ERR;
      tag       = TAG_NONE;
      pair      = 1'b0;
    end
  end

  assign state_o             = nxt;
  assign result_o.field_tag  = tag;
  assign result_o.field_byte = (tag != TAG_NONE) ? c : 8'd0;
  assign result_o.pair_done  = pair;
  assign result_o.status     = status;

endmodule

FILE: sv/http_request_header_parser.sv
// ----------------------------------------------------------------------------
// http_request_header_parser
// Streaming HTTP request line and header checker, one byte per item.
// ----------------------------------------------------------------------------
// Each accepted byte gives exactly one result item: a field tag with the byte,
// a header pair-done mark and a status. Throughput is one byte per clock while
// the downstream side keeps ready; a byte passes through the input register,
// then the result register, and the parser state advances as the byte moves
// from the input register into the result register. The input stays ready
// while the result register is full as long as the downstream side takes
// that result in the same cycle. Done and error are sticky until an item
// with restart set arrives.
module http_request_header_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  hrhp_stream_if.sink   in_i,
  hrhp_stream_if.source out_o
);
  import hrhp_pkg::*;

  in_item_t  in_q;
  logic      in_vld_q;
  out_item_t res_q;
  out_item_t res_d;
  logic      res_vld_q;
  state_t    state_q;
  state_t    state_d;
  logic      advance;

  // Input register moves on when the result register is free or draining
  assign advance    = in_vld_q && (!res_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  hrhp_step u_step (
    .state_i  (state_q),
    .item_i   (in_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Control: valid flags and parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
      state_q   <= STATE_RESET;
    end else begin
      if (in_i.ready) in_vld_q <= in_i.valid;
      if (advance) begin
        res_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (out_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) in_q <= in_i.payload;
    if (advance) res_q <= res_d;
  end

  assign out_o.valid   = res_vld_q;
  assign out_o.payload = res_q;

endmodule
